// ----- rtl/dtp_pkg.sv -----
// Shared types and constants for the decimal timestamp parser.
// No dependencies; imported by dtp_in_reg, dtp_parse and the top level.
`default_nettype none

package dtp_pkg;

    localparam logic [7:0]  POINT_CHAR      = 8'h2E;
    localparam logic [7:0]  NUL_CHAR        = 8'h00;
    localparam logic [7:0]  DIGIT_ZERO      = 8'h30;
    localparam logic [7:0]  DIGIT_NINE      = 8'h39;
    localparam logic [3:0]  FRAC_MAX_DIGITS = 4'd9;
    localparam logic [3:0]  COUNT_SAT       = 4'd10;
    localparam logic [29:0] NS_PER_SEC      = 30'd1000000000;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_WHOLE = 3'd1,
        PH_FRAC  = 3'd2,
        PH_ENDED = 3'd3,
        PH_BAD   = 3'd4
    } phase_t;

    // One character transfer as held in the input register.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } dtp_item_t;

    function automatic logic [29:0] pow10(input logic [3:0] idx);
        logic [29:0] p;
        unique case (idx)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = NS_PER_SEC;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dtp_in_reg.sv -----
// Input register of the decimal timestamp parser.
// Depends on dtp_pkg for the item struct.
`default_nettype none

module dtp_in_reg
    import dtp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire logic [7:0] s_char_code,
    input  wire logic      s_end_of_string,
    input  wire logic      consume,
    output logic           item_valid,
    output dtp_item_t      item
);

    logic      valid_reg, valid_next;
    dtp_item_t item_reg;
    logic      load;

    // Refill in the same cycle the held item moves on.
    assign s_ready = !valid_reg || consume;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.char_code     <= s_char_code;
            item_reg.end_of_string <= s_end_of_string;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- rtl/dtp_parse.sv -----
// Parse state machine, accumulators and result register.
// Depends on dtp_pkg for phase codes, constants and the power-of-ten table.
`default_nettype none

module dtp_parse
    import dtp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        item_valid,
    input  wire dtp_item_t   item,
    output logic             consume,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic [63:0]      m_seconds,
    output logic [29:0]      m_nanoseconds
);

    phase_t      phase_reg, phase_next;
    logic [63:0] whole_reg, whole_next;
    logic [29:0] frac_reg, frac_next;
    logic [3:0]  count_reg, count_next;

    logic        m_valid_reg, m_valid_next;
    logic        status_reg, status_next;
    logic [63:0] seconds_reg, seconds_next;
    logic [29:0] ns_reg, ns_next;

    logic        out_free;
    logic        is_digit;
    logic [3:0]  digit;
    logic [63:0] whole_step;
    logic [29:0] frac_step;
    logic        ok;
    logic [59:0] ns_prod;
    logic        emit;

    assign out_free = !m_valid_reg || m_ready;
    // Character transfers never wait; a terminator waits for a free result slot.
    assign consume  = item_valid && (!item.end_of_string || out_free);
    assign emit     = consume && item.end_of_string;

    assign is_digit   = (item.char_code >= DIGIT_ZERO) && (item.char_code <= DIGIT_NINE);
    assign digit      = item.char_code[3:0];
    assign whole_step = {whole_reg[60:0], 3'b000} + {whole_reg[62:0], 1'b0} + 64'(digit);
    assign frac_step  = {frac_reg[26:0], 3'b000} + {frac_reg[28:0], 1'b0} + 30'(digit);

    assign ok = ((phase_reg == PH_FRAC) || (phase_reg == PH_ENDED))
             && (count_reg >= 4'd1) && (count_reg <= FRAC_MAX_DIGITS);
    assign ns_prod = 60'(frac_reg) * 60'(pow10(FRAC_MAX_DIGITS - count_reg));

    always_comb begin
        phase_next = phase_reg;
        whole_next = whole_reg;
        frac_next  = frac_reg;
        count_next = count_reg;
        if (consume) begin
            if (item.end_of_string) begin
                phase_next = PH_START;
                whole_next = '0;
                frac_next  = '0;
                count_next = '0;
            end else begin
                unique case (phase_reg)
                    PH_START, PH_WHOLE: begin
                        if (is_digit) begin
                            whole_next = whole_step;
                            phase_next = PH_WHOLE;
                        end else if (item.char_code == POINT_CHAR
                                     && phase_reg == PH_WHOLE) begin
                            phase_next = PH_FRAC;
                        end else begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit) begin
                            // Drop digits past the ninth; the count still marks the overflow.
                            if (count_reg < FRAC_MAX_DIGITS) begin
                                frac_next = frac_step;
                            end
                            if (count_reg < COUNT_SAT) begin
                                count_next = count_reg + 4'd1;
                            end
                        end else if (item.char_code == NUL_CHAR) begin
                            phase_next = PH_ENDED;
                        end else begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_ENDED, PH_BAD: begin
                        phase_next = phase_reg;
                    end
                    default: begin
                        phase_next = PH_BAD;
                    end
                endcase
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        seconds_next = seconds_reg;
        ns_next      = ns_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            if (ok) begin
                status_next  = 1'b0;
                seconds_next = whole_reg;
                ns_next      = ns_prod[29:0];
            end else begin
                status_next  = 1'b1;
                seconds_next = '0;
                ns_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            whole_reg   <= '0;
            frac_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            whole_reg   <= whole_next;
            frac_reg    <= frac_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        seconds_reg <= seconds_next;
        ns_reg      <= ns_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_seconds     = seconds_reg;
    assign m_nanoseconds = ns_reg;

endmodule

`default_nettype wire

// ----- rtl/decimal_timestamp_parser.sv -----
// Decimal timestamp parser: text "<digits>.<digits>" to seconds and nanoseconds.
//
// Input channel (s_): one byte of text per transfer on s_char_code; a transfer
// with s_end_of_string high is the terminator and carries no character.
// Result channel (m_): one result per terminator: m_status 0 for a well-formed
// text with m_seconds (modulo 2^64) and m_nanoseconds, m_status 1 otherwise
// with both values zero. A zero byte after the point ends the text early; later
// bytes up to the terminator are ignored.
// Throughput: one byte per cycle while no terminator is held back, set by the
// single multiply-by-ten and add step between the input register and parse state.
// Result path: an accepted terminator passes from the input register into the
// result register once that register is free, and m_valid rises from there.
// Stall: while m_valid waits on m_ready, character bytes keep flowing into the
// parser; a second terminator waits in the input register until the pending
// result is taken, and s_ready then drops.
// Reset: synchronous, active-low aresetn empties both registers and returns
// the parser to its start phase with cleared accumulators.
// Depends on dtp_pkg, dtp_in_reg and dtp_parse.
`default_nettype none

module decimal_timestamp_parser
    import dtp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_end_of_string,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic [63:0]      m_seconds,
    output logic [29:0]      m_nanoseconds
);

    logic      item_valid;
    dtp_item_t item;
    logic      consume;

    dtp_in_reg u_in_reg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_of_string (s_end_of_string),
        .consume         (consume),
        .item_valid      (item_valid),
        .item            (item)
    );

    dtp_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (item_valid),
        .item          (item),
        .consume       (consume),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_seconds     (m_seconds),
        .m_nanoseconds (m_nanoseconds)
    );

endmodule

`default_nettype wire

// ----- rtl/dtp_checker.sv -----
// Port-level checks for the decimal timestamp parser, bound to the top level.
// Depends only on the top-level port list.
`default_nettype none

module dtp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [7:0]  s_char_code,
    input wire logic        s_end_of_string,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_status,
    input wire logic [63:0] m_seconds,
    input wire logic [29:0] m_nanoseconds
);

    // Hold a stalled input transfer.
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_char_code)
            && $stable(s_end_of_string))
        else $error("stalled input transfer changed");

    // Hold a stalled result.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_seconds) && $stable(m_nanoseconds))
        else $error("stalled result changed");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_seconds == 64'd0 && m_nanoseconds == 30'd0)
        else $error("malformed result carries nonzero values");

    a_ns_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> m_nanoseconds < 30'd1000000000)
        else $error("nanoseconds out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind decimal_timestamp_parser dtp_checker u_dtp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_char_code     (s_char_code),
    .s_end_of_string (s_end_of_string),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_seconds       (m_seconds),
    .m_nanoseconds   (m_nanoseconds)
);

`default_nettype wire
